[rtl/core/rmv_pkg.sv]
package rmv_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int FRAC_SHIFT = 16;
  localparam int MEAN_W     = SAMPLE_W + FRAC_SHIFT;
  localparam int DIFF_W     = MEAN_W + 1;
  localparam int VAR_W      = 63;
  localparam int CNT_W      = 32;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int PROD_SHIFT = 32;

  localparam int DIV_STEPS  = VAR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int MUL_STEPS  = DIFF_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  typedef struct packed {
    logic             start;
    logic [VAR_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] b;
  } mul_req_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIFF   = 10'b0000000010,
    S_MDIV   = 10'b0000000100,
    S_ERR    = 10'b0000001000,
    S_EMAG   = 10'b0000010000,
    S_MUL    = 10'b0000100000,
    S_ACC    = 10'b0001000000,
    S_VSTART = 10'b0010000000,
    S_VDIV   = 10'b0100000000,
    S_WRITE  = 10'b1000000000
  } state_t;

endpackage

[rtl/core/rmv_if.sv]
interface rmv_in_if import rmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, action, sample, input ready);
  modport sink   (input valid, action, sample, output ready);
endinterface

interface rmv_out_if import rmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] running_mean;
  logic [VAR_W-1:0]         variance;
  logic [CNT_W-1:0]         count_seen;
  logic                     saturated;

  modport source (output valid, running_mean, variance, count_seen, saturated, input ready);
  modport sink   (input valid, running_mean, variance, count_seen, saturated, output ready);
endinterface

[rtl/core/running_mean_variance.sv]
// Running mean and population variance (Welford) over signed Q16.16 samples.
// Input channel in_ch: valid/ready with action (0 add, 1 clear) and sample.
// Output channel out_ch: valid/ready with running_mean (Q16.32), variance
// (Q31.32), count_seen and saturated; one result per accepted request.
// An add runs from acceptance to result through the serial divide of the
// mean step (63 quotient bits), the 49-step shift-add multiply of the
// deviation product and the serial divide of the variance, with six
// single-state steps around them. The divider retires one quotient bit per
// cycle and is shared by both divides; with the multiply it sets the rate.
// A clear goes from acceptance straight to the write state and uses neither
// unit. One request is worked at a time; in_ch.ready is high only while idle,
// so a new request is taken only once the last result is in the output register.
// The result sits in an output register, so the next request is taken while
// a finished result still waits; when the receiver stalls and the output
// register is full, the block holds its next result and then stops taking
// requests until the output frees up.
// Count and sum of squared deviations saturate and raise saturated.
// Reset (rst_n low, synchronous) zeroes all statistics and empties the
// output register.
module running_mean_variance import rmv_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  rmv_in_if.sink     in_ch,
  rmv_out_if.source  out_ch
);

  state_t            state_r;
  state_t            state_nxt;

  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  sq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              sat_r;
  logic [VAR_W-1:0]  var_r;

  logic [MEAN_W-1:0] x_r;
  logic [DIFF_W-1:0] d_r;
  logic [DIFF_W-1:0] dmag_r;
  logic [DIFF_W-1:0] e_r;
  logic [VAR_W-1:0]  prod_r;
  logic              mulsat_r;

  logic              out_valid_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [VAR_W-1:0]  out_var_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_sat_r;

  logic              accept;
  logic              out_free;
  logic              write_fire;
  logic [MEAN_W-1:0] x_in;
  logic [DIFF_W-1:0] d_in;
  logic [DIFF_W-1:0] dmag_now;
  logic [DIFF_W-1:0] e_now;
  logic [DIFF_W-1:0] emag;
  logic [MEAN_W-1:0] q_mean;
  logic [MEAN_W-1:0] mean_upd;
  logic [VAR_W:0]    acc_sum;

  div_req_t          div_req;
  unit_stat_t        div_stat;
  logic [VAR_W-1:0]  div_quo;
  mul_req_t          mul_req;
  unit_stat_t        mul_stat;
  logic [PROD_W-1:0] mul_prod;

  assign accept     = in_ch.valid & in_ch.ready;
  assign out_free   = ~out_valid_r | out_ch.ready;
  assign write_fire = (state_r == S_WRITE) & out_free;

  assign x_in     = {in_ch.sample, {FRAC_SHIFT{1'b0}}};
  assign d_in     = {x_in[MEAN_W-1], x_in} - {mean_r[MEAN_W-1], mean_r};
  assign dmag_now = d_r[DIFF_W-1] ? (~d_r + DIFF_W'(1)) : d_r;
  assign e_now    = {x_r[MEAN_W-1], x_r} - {mean_r[MEAN_W-1], mean_r};
  assign emag     = e_r[DIFF_W-1] ? (~e_r + DIFF_W'(1)) : e_r;
  assign q_mean   = div_quo[MEAN_W-1:0];
  assign mean_upd = d_r[DIFF_W-1] ? (mean_r - q_mean) : (mean_r + q_mean);
  assign acc_sum  = {1'b0, sq_r} + {1'b0, prod_r};

  assign div_req.start    = (state_r == S_DIFF) | (state_r == S_VSTART);
  assign div_req.dividend = (state_r == S_VSTART) ? sq_r
                                                  : {{(VAR_W-DIFF_W){1'b0}}, dmag_now};
  assign div_req.divisor  = cnt_r;

  assign mul_req.start = (state_r == S_EMAG);
  assign mul_req.a     = dmag_r;
  assign mul_req.b     = emag;

  rmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  rmv_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = in_ch.action ? S_WRITE : S_DIFF;
      end
      S_DIFF:   state_nxt = S_MDIV;
      S_MDIV: begin
        if (div_stat.done) state_nxt = S_ERR;
      end
      S_ERR:    state_nxt = S_EMAG;
      S_EMAG:   state_nxt = S_MUL;
      S_MUL: begin
        if (mul_stat.done) state_nxt = S_ACC;
      end
      S_ACC:    state_nxt = S_VSTART;
      S_VSTART: state_nxt = S_VDIV;
      S_VDIV: begin
        if (div_stat.done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mean_r      <= '0;
      sq_r        <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_ch.action) begin
          mean_r <= '0;
          sq_r   <= '0;
          cnt_r  <= '0;
          sat_r  <= 1'b0;
          var_r  <= '0;
        end else if (cnt_r == CNT_MAX) begin
          sat_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if ((state_r == S_MDIV) && div_stat.done) mean_r <= mean_upd;
      if (state_r == S_ACC) begin
        if (mulsat_r || acc_sum[VAR_W]) begin
          sq_r  <= VAR_MAX;
          sat_r <= 1'b1;
        end else begin
          sq_r <= acc_sum[VAR_W-1:0];
        end
      end
      if ((state_r == S_VDIV) && div_stat.done) var_r <= div_quo;
      if (write_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_in;
      d_r <= d_in;
    end
    if (state_r == S_DIFF) dmag_r <= dmag_now;
    if (state_r == S_ERR) e_r <= e_now;
    // keep the Q.32 part of the product (bits 94:32); anything above bit 94 overflows
    if ((state_r == S_MUL) && mul_stat.done) begin
      prod_r   <= mul_prod[PROD_SHIFT+VAR_W-1:PROD_SHIFT];
      mulsat_r <= |mul_prod[PROD_W-1:PROD_SHIFT+VAR_W];
    end
    if (write_fire) begin
      out_mean_r <= mean_r;
      out_var_r  <= var_r;
      out_cnt_r  <= cnt_r;
      out_sat_r  <= sat_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.running_mean = out_mean_r;
  assign out_ch.variance     = out_var_r;
  assign out_ch.count_seen   = out_cnt_r;
  assign out_ch.saturated    = out_sat_r;

`ifndef SYNTH
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!div_stat.busy && !mul_stat.busy))
    else $error("request taken while an arithmetic unit is busy");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.action) |=> (cnt_r == '0 && !sat_r && state_r == S_WRITE))
    else $error("clear did not zero the statistics");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_stat.busy && mul_stat.busy))
    else $error("divider and multiplier active together");
`endif

endmodule

[rtl/core/rmv_div.sv]
module rmv_div import rmv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output unit_stat_t       stat,
  output logic [VAR_W-1:0] quotient
);

  logic [VAR_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W+1:0]     diff;
  logic                 fits;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_r, quo_r[VAR_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits   = ~diff[CNT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_CNT_W'(1);
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VAR_W-2:0], fits};
      rem_r <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[rtl/core/rmv_mul.sv]
module rmv_mul import rmv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mul_req_t          req,
  output unit_stat_t        stat,
  output logic [PROD_W-1:0] product
);

  logic [DIFF_W-1:0]    a_r;
  logic [DIFF_W-1:0]    hi_r;
  logic [DIFF_W-1:0]    lo_r;
  logic [MUL_CNT_W-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIFF_W:0]      sum;

  // add the multiplicand when the low bit is set, then shift the pair right
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + MUL_CNT_W'(1);
        if (step_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      hi_r <= '0;
      lo_r <= req.b;
    end else if (busy_r) begin
      hi_r <= sum[DIFF_W:1];
      lo_r <= {sum[0], lo_r[DIFF_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r, lo_r};

endmodule
